/* hdl/rgb_to_hsl_converter_macros.svh */
// Assertion helpers shared by the converter RTL.
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// Plain property, checked on every clock edge out of reset.
`define RTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle.
`define RTH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hdl/rth_pkg.sv */
package rth_pkg;

  localparam int RgbW           = 8;
  localparam int HueW           = 11;
  localparam int SatW           = 8;
  localparam int LightW         = 9;
  localparam int HueSectorSteps = 256;
  localparam int InDataW        = 24;
  localparam int OutDataW       = 32;

  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

  // sideband that rides along the divider row
  typedef struct packed {
    sector_e           sector;
    logic              neg;
    logic              gray;
    logic [LightW-1:0] light;
  } side_t;

endpackage

/* hdl/rth_front.sv */
module rth_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [rth_pkg::RgbW-1:0]       red_i,
  input  logic [rth_pkg::RgbW-1:0]       green_i,
  input  logic [rth_pkg::RgbW-1:0]       blue_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output rth_pkg::sector_e               sector_o,
  output logic signed [rth_pkg::RgbW:0]  num_o,
  output logic [rth_pkg::RgbW-1:0]       d_o,
  output logic [rth_pkg::LightW-1:0]     sum_o
);

  logic                          valid_q;
  rth_pkg::sector_e              sector_d, sector_q;
  logic signed [rth_pkg::RgbW:0] num_d, num_q;
  logic [rth_pkg::RgbW-1:0]      mx, mn, d_d, d_q;
  logic [rth_pkg::LightW-1:0]    sum_d, sum_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    d_d   = mx - mn;
    sum_d = {1'b0, mx} + {1'b0, mn};
    if (red_i >= green_i && red_i >= blue_i) begin
      sector_d = rth_pkg::SecRed;
      num_d    = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= blue_i) begin
      sector_d = rth_pkg::SecGreen;
      num_d    = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sector_d = rth_pkg::SecBlue;
      num_d    = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sector_q <= sector_d;
      num_q    <= num_d;
      d_q      <= d_d;
      sum_q    <= sum_d;
    end
  end

  assign valid_o  = valid_q;
  assign sector_o = sector_q;
  assign num_o    = num_q;
  assign d_o      = d_q;
  assign sum_o    = sum_q;

endmodule

/* hdl/rth_prep.sv */
module rth_prep #(
  parameter int HueSteps = rth_pkg::HueSectorSteps,
  parameter int DvdW     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  rth_pkg::sector_e               sector_i,
  input  logic signed [rth_pkg::RgbW:0]  num_i,
  input  logic [rth_pkg::RgbW-1:0]       d_i,
  input  logic [rth_pkg::LightW-1:0]     sum_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [DvdW-1:0]                hdvd_o,
  output logic [rth_pkg::RgbW-1:0]       hdvs_o,
  output logic [DvdW-1:0]                sdvd_o,
  output logic [rth_pkg::RgbW-1:0]       sdvs_o,
  output rth_pkg::side_t                 side_o
);

  logic                     valid_q;
  logic [rth_pkg::RgbW-1:0] absn;
  logic [DvdW-1:0]          hdvd_d, hdvd_q, sdvd_d, sdvd_q;
  logic [rth_pkg::RgbW-1:0] den_d, den_q, dvs_q;
  rth_pkg::side_t           side_d, side_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    absn   = num_i[rth_pkg::RgbW] ? rth_pkg::RgbW'(-num_i) : num_i[rth_pkg::RgbW-1:0];
    hdvd_d = DvdW'(absn) * DvdW'(HueSteps);
    // 255 * d
    sdvd_d = DvdW'({d_i, {rth_pkg::RgbW{1'b0}}}) - DvdW'(d_i);
    if (sum_i <= rth_pkg::LightW'(255)) begin
      den_d = sum_i[rth_pkg::RgbW-1:0];
    end else begin
      den_d = rth_pkg::RgbW'(rth_pkg::LightW'(510) - sum_i);
    end
    side_d.sector = sector_i;
    side_d.neg    = num_i[rth_pkg::RgbW];
    side_d.gray   = (d_i == '0);
    side_d.light  = sum_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hdvd_q <= hdvd_d;
      sdvd_q <= sdvd_d;
      dvs_q  <= d_i;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign hdvd_o  = hdvd_q;
  assign hdvs_o  = dvs_q;
  assign sdvd_o  = sdvd_q;
  assign sdvs_o  = den_q;
  assign side_o  = side_q;

endmodule

/* hdl/rth_div_cell.sv */
module rth_div_cell #(
  parameter int DvdW = 16,
  parameter int QhW  = 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [DvdW-1:0]            hdvd_i,
  input  logic [rth_pkg::RgbW-1:0]   hdvs_i,
  input  logic [rth_pkg::RgbW-1:0]   hrem_i,
  input  logic [QhW-1:0]             hq_i,
  input  logic [DvdW-1:0]            sdvd_i,
  input  logic [rth_pkg::RgbW-1:0]   sdvs_i,
  input  logic [rth_pkg::RgbW-1:0]   srem_i,
  input  logic [rth_pkg::SatW-1:0]   sq_i,
  input  rth_pkg::side_t             side_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [DvdW-1:0]            hdvd_o,
  output logic [rth_pkg::RgbW-1:0]   hdvs_o,
  output logic [rth_pkg::RgbW-1:0]   hrem_o,
  output logic [QhW-1:0]             hq_o,
  output logic [DvdW-1:0]            sdvd_o,
  output logic [rth_pkg::RgbW-1:0]   sdvs_o,
  output logic [rth_pkg::RgbW-1:0]   srem_o,
  output logic [rth_pkg::SatW-1:0]   sq_o,
  output rth_pkg::side_t             side_o
);

  logic                     valid_q;
  logic [rth_pkg::RgbW:0]   hsh, ssh;
  logic                     hge, sge;
  logic [rth_pkg::RgbW-1:0] hrem_d, srem_d;
  logic [DvdW-1:0]          hdvd_q, sdvd_q;
  logic [rth_pkg::RgbW-1:0] hdvs_q, hrem_q, sdvs_q, srem_q;
  logic [QhW-1:0]           hq_q;
  logic [rth_pkg::SatW-1:0] sq_q;
  rth_pkg::side_t           side_q;

  assign ready_o = !valid_q || ready_i;

  // one restoring step per lane
  always_comb begin
    hsh    = {hrem_i, hdvd_i[DvdW-1]};
    hge    = (hsh >= {1'b0, hdvs_i});
    hrem_d = hge ? rth_pkg::RgbW'(hsh - {1'b0, hdvs_i}) : hsh[rth_pkg::RgbW-1:0];
    ssh    = {srem_i, sdvd_i[DvdW-1]};
    sge    = (ssh >= {1'b0, sdvs_i});
    srem_d = sge ? rth_pkg::RgbW'(ssh - {1'b0, sdvs_i}) : ssh[rth_pkg::RgbW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hdvd_q <= {hdvd_i[DvdW-2:0], 1'b0};
      hdvs_q <= hdvs_i;
      hrem_q <= hrem_d;
      hq_q   <= {hq_i[QhW-2:0], hge};
      sdvd_q <= {sdvd_i[DvdW-2:0], 1'b0};
      sdvs_q <= sdvs_i;
      srem_q <= srem_d;
      sq_q   <= {sq_i[rth_pkg::SatW-2:0], sge};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign hdvd_o  = hdvd_q;
  assign hdvs_o  = hdvs_q;
  assign hrem_o  = hrem_q;
  assign hq_o    = hq_q;
  assign sdvd_o  = sdvd_q;
  assign sdvs_o  = sdvs_q;
  assign srem_o  = srem_q;
  assign sq_o    = sq_q;
  assign side_o  = side_q;

endmodule

/* hdl/rth_back.sv */
module rth_back #(
  parameter int HueSteps = rth_pkg::HueSectorSteps,
  parameter int QhW      = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [QhW-1:0]               hq_i,
  input  logic [rth_pkg::SatW-1:0]     sq_i,
  input  rth_pkg::side_t               side_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [rth_pkg::HueW-1:0]     hue_o,
  output logic [rth_pkg::SatW-1:0]     sat_o,
  output logic [rth_pkg::LightW-1:0]   light_o
);

  localparam int HcW = $clog2(6 * HueSteps + 1) + 2;
  localparam int HxW = (HcW > rth_pkg::HueW) ? HcW : rth_pkg::HueW;

  logic                          valid_q;
  logic signed [HcW-1:0]         base, qs, hs;
  logic [HxW-1:0]                hue_x;
  logic [rth_pkg::HueW-1:0]      hue_d, hue_q;
  logic [rth_pkg::SatW-1:0]      sat_d, sat_q;
  logic [rth_pkg::LightW-1:0]    light_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    case (side_i.sector)
      rth_pkg::SecRed:   base = '0;
      rth_pkg::SecGreen: base = HcW'(2 * HueSteps);
      rth_pkg::SecBlue:  base = HcW'(4 * HueSteps);
      default:           base = '0;
    endcase
    qs = $signed(HcW'(hq_i));
    hs = side_i.neg ? (base - qs) : (base + qs);
    if (hs < 0) begin
      hs = hs + HcW'(6 * HueSteps);
    end
    hue_x = HxW'($unsigned(hs));
    if (side_i.gray) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = hue_x[rth_pkg::HueW-1:0];
      sat_d = sq_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      light_q <= side_i.light;
    end
  end

  assign valid_o = valid_q;
  assign hue_o   = hue_q;
  assign sat_o   = sat_q;
  assign light_o = light_q;

endmodule

/* hdl/rgb_to_hsl_converter.sv */
// Channel   Dir  Fields (tdata from bit 0 up)                        Width
// s_axis    in   red[7:0] green[15:8] blue[23:16]                      24
// m_axis    out  hue[10:0] saturation[18:11] lightness[27:19], 0 pad   32
//
// One pixel per cycle sustained while m_axis is not stalled. The pipeline is
// a min/max stage, an operand stage, one restoring-division cell per dividend
// bit and an output register. Hue and saturation divide side by side in each
// cell. Reset clears only the valid bits of every stage. A stall on m_axis
// backs up stage by stage; empty stages keep accepting.
`include "rgb_to_hsl_converter_macros.svh"

module rgb_to_hsl_converter #(
  parameter int HUE_SECTOR_STEPS = rth_pkg::HueSectorSteps
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [rth_pkg::InDataW-1:0]     s_axis_tdata_i,  // red, green, blue
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [rth_pkg::OutDataW-1:0]    m_axis_tdata_o   // hue, saturation, lightness
);

  localparam int QhW      = $clog2(HUE_SECTOR_STEPS + 1);
  localparam int HdvdW    = $clog2(255 * HUE_SECTOR_STEPS + 1);
  localparam int DvdW     = (HdvdW > 16) ? HdvdW : 16;
  localparam int NumCells = DvdW;
  localparam int HueSpan  = 6 * HUE_SECTOR_STEPS;
  localparam int PadW     = rth_pkg::OutDataW - rth_pkg::HueW - rth_pkg::SatW
                            - rth_pkg::LightW;

  logic                              f_valid, f_ready;
  rth_pkg::sector_e                  f_sector;
  logic signed [rth_pkg::RgbW:0]     f_num;
  logic [rth_pkg::RgbW-1:0]          f_d;
  logic [rth_pkg::LightW-1:0]        f_sum;

  logic                              c_valid [NumCells+1];
  logic                              c_ready [NumCells+1];
  logic [DvdW-1:0]                   c_hdvd  [NumCells+1];
  logic [rth_pkg::RgbW-1:0]          c_hdvs  [NumCells+1];
  logic [rth_pkg::RgbW-1:0]          c_hrem  [NumCells+1];
  logic [QhW-1:0]                    c_hq    [NumCells+1];
  logic [DvdW-1:0]                   c_sdvd  [NumCells+1];
  logic [rth_pkg::RgbW-1:0]          c_sdvs  [NumCells+1];
  logic [rth_pkg::RgbW-1:0]          c_srem  [NumCells+1];
  logic [rth_pkg::SatW-1:0]          c_sq    [NumCells+1];
  rth_pkg::side_t                    c_side  [NumCells+1];

  logic [rth_pkg::HueW-1:0]          hue;
  logic [rth_pkg::SatW-1:0]          sat;
  logic [rth_pkg::LightW-1:0]        light;

  rth_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid_i),
    .ready_o  (s_axis_tready_o),
    .red_i    (s_axis_tdata_i[rth_pkg::RgbW-1:0]),
    .green_i  (s_axis_tdata_i[2*rth_pkg::RgbW-1:rth_pkg::RgbW]),
    .blue_i   (s_axis_tdata_i[3*rth_pkg::RgbW-1:2*rth_pkg::RgbW]),
    .valid_o  (f_valid),
    .ready_i  (f_ready),
    .sector_o (f_sector),
    .num_o    (f_num),
    .d_o      (f_d),
    .sum_o    (f_sum)
  );

  rth_prep #(
    .HueSteps (HUE_SECTOR_STEPS),
    .DvdW     (DvdW)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (f_valid),
    .ready_o  (f_ready),
    .sector_i (f_sector),
    .num_i    (f_num),
    .d_i      (f_d),
    .sum_i    (f_sum),
    .valid_o  (c_valid[0]),
    .ready_i  (c_ready[0]),
    .hdvd_o   (c_hdvd[0]),
    .hdvs_o   (c_hdvs[0]),
    .sdvd_o   (c_sdvd[0]),
    .sdvs_o   (c_sdvs[0]),
    .side_o   (c_side[0])
  );

  assign c_hrem[0] = '0;
  assign c_hq[0]   = '0;
  assign c_srem[0] = '0;
  assign c_sq[0]   = '0;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    rth_div_cell #(
      .DvdW (DvdW),
      .QhW  (QhW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[k]),
      .ready_o (c_ready[k]),
      .hdvd_i  (c_hdvd[k]),
      .hdvs_i  (c_hdvs[k]),
      .hrem_i  (c_hrem[k]),
      .hq_i    (c_hq[k]),
      .sdvd_i  (c_sdvd[k]),
      .sdvs_i  (c_sdvs[k]),
      .srem_i  (c_srem[k]),
      .sq_i    (c_sq[k]),
      .side_i  (c_side[k]),
      .valid_o (c_valid[k+1]),
      .ready_i (c_ready[k+1]),
      .hdvd_o  (c_hdvd[k+1]),
      .hdvs_o  (c_hdvs[k+1]),
      .hrem_o  (c_hrem[k+1]),
      .hq_o    (c_hq[k+1]),
      .sdvd_o  (c_sdvd[k+1]),
      .sdvs_o  (c_sdvs[k+1]),
      .srem_o  (c_srem[k+1]),
      .sq_o    (c_sq[k+1]),
      .side_o  (c_side[k+1])
    );
  end

  rth_back #(
    .HueSteps (HUE_SECTOR_STEPS),
    .QhW      (QhW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid[NumCells]),
    .ready_o (c_ready[NumCells]),
    .hq_i    (c_hq[NumCells]),
    .sq_i    (c_sq[NumCells]),
    .side_i  (c_side[NumCells]),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .hue_o   (hue),
    .sat_o   (sat),
    .light_o (light)
  );

  assign m_axis_tdata_o = {{PadW{1'b0}}, light, sat, hue};

  `RTH_ASSERT_IMP(a_hue_rem, c_valid[NumCells] && !c_side[NumCells].gray, c_hrem[NumCells] < c_hdvs[NumCells], "hue remainder not below divisor")
  `RTH_ASSERT_IMP(a_sat_rem, c_valid[NumCells] && !c_side[NumCells].gray, c_srem[NumCells] < c_sdvs[NumCells], "saturation remainder not below divisor")
  `RTH_ASSERT_IMP(a_dvd_done, c_valid[NumCells], (c_hdvd[NumCells] == '0) && (c_sdvd[NumCells] == '0), "dividend bits left after last cell")
  `RTH_ASSERT_IMP(a_hue_range, m_axis_tvalid_o && (HueSpan < (1 << rth_pkg::HueW)), hue < rth_pkg::HueW'(HueSpan), "hue out of range")

endmodule
